@@ design/nmea_gga_gsa_checksum_parser_unit_defines.svh @@
// ----------------------------------------------------------------------------
// NMEA GGA/GSA parser assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_GSA_CHECKSUM_PARSER_UNIT_DEFINES_SVH
`define NMEA_GGA_GSA_CHECKSUM_PARSER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define NGGCP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("nggcp: invariant violated");

// consequent holds in the same cycle as the antecedent
`define NGGCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nggcp: implication violated");

// consequent holds in the cycle after the antecedent
`define NGGCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nggcp: next-cycle implication violated");

`endif

@@ design/nggcp_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA GGA/GSA parser package
// Types, character codes, field codes and position tables of the parser.
// ----------------------------------------------------------------------------
package nggcp_pkg;

  localparam int CHAR_W = 8;
  localparam int FID_W  = 4;
  localparam int IDX_W  = 7;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [FID_W-1:0]  fid_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_G      = 8'h47;
  localparam char_t CH_P      = 8'h50;
  localparam char_t CH_S      = 8'h53;
  localparam char_t CH_A      = 8'h41;
  localparam char_t CH_F      = 8'h46;
  localparam char_t CH_LA     = 8'h61;
  localparam char_t CH_LF     = 8'h66;
  localparam char_t CH_0      = 8'h30;
  localparam char_t CH_9      = 8'h39;

  localparam fid_t FID_UNIT = 4'd10;
  localparam fid_t FID_SAT  = 4'd11;

  localparam idx_t GGA_COUNT  = 7'd39;
  localparam idx_t GSA_FIRST  = 7'd8;
  localparam idx_t GSA_LIMIT  = 7'd64;
  localparam logic [3:0] GSA_COMMAS = 4'd8;

  typedef struct packed {
    logic restart;
    logic take;
    logic set_kind;
    logic hex_first;
    logic emit_init;
    logic emit_load;
  } nggcp_cmd_t;

  typedef struct packed {
    logic is_dollar;
    logic is_g;
    logic is_p;
    logic is_s;
    logic is_a;
    logic is_star;
    logic sum_ok;
    logic none_to_send;
    logic out_taken;
    logic out_last;
  } nggcp_sts_t;

  function automatic logic [4:0] hex_decode(input char_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_A && c <= CH_F) begin
      r = {1'b1, 4'(c - CH_A + 8'd10)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [5:0] gga_pos(input idx_t i);
    logic [5:0] p;
    case (i)
      7'd0:  p = 6'd6;   7'd1:  p = 6'd7;   7'd2:  p = 6'd8;   7'd3:  p = 6'd9;
      7'd4:  p = 6'd10;  7'd5:  p = 6'd11;  7'd6:  p = 6'd12;  7'd7:  p = 6'd13;
      7'd8:  p = 6'd14;  7'd9:  p = 6'd16;  7'd10: p = 6'd17;  7'd11: p = 6'd18;
      7'd12: p = 6'd19;  7'd13: p = 6'd20;  7'd14: p = 6'd21;  7'd15: p = 6'd22;
      7'd16: p = 6'd23;  7'd17: p = 6'd24;  7'd18: p = 6'd25;  7'd19: p = 6'd27;
      7'd20: p = 6'd29;  7'd21: p = 6'd30;  7'd22: p = 6'd31;  7'd23: p = 6'd32;
      7'd24: p = 6'd33;  7'd25: p = 6'd34;  7'd26: p = 6'd35;  7'd27: p = 6'd36;
      7'd28: p = 6'd37;  7'd29: p = 6'd38;  7'd30: p = 6'd39;  7'd31: p = 6'd41;
      7'd32: p = 6'd53;  7'd33: p = 6'd54;  7'd34: p = 6'd55;  7'd35: p = 6'd56;
      7'd36: p = 6'd57;  7'd37: p = 6'd58;  7'd38: p = 6'd60;
      default: p = 6'd0;
    endcase
    return p;
  endfunction

  function automatic fid_t gga_fid(input idx_t i);
    fid_t f;
    if (i < 7'd2) begin
      f = 4'd0;
    end else if (i < 7'd4) begin
      f = 4'd1;
    end else if (i < 7'd9) begin
      f = 4'd2;
    end else if (i < 7'd11) begin
      f = 4'd3;
    end else if (i < 7'd19) begin
      f = 4'd4;
    end else if (i < 7'd20) begin
      f = 4'd5;
    end else if (i < 7'd23) begin
      f = 4'd6;
    end else if (i < 7'd31) begin
      f = 4'd7;
    end else if (i < 7'd32) begin
      f = 4'd8;
    end else if (i < 7'd38) begin
      f = 4'd9;
    end else begin
      f = FID_UNIT;
    end
    return f;
  endfunction

endpackage

@@ design/nggcp_in_if.sv @@
// ----------------------------------------------------------------------------
// NMEA parser input channel
// Valid/ready channel carrying one received sentence byte per transfer.
// ----------------------------------------------------------------------------
interface nggcp_in_if;
  import nggcp_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

@@ design/nggcp_out_if.sv @@
// ----------------------------------------------------------------------------
// NMEA parser result channel
// Valid/ready channel carrying one extracted character per transfer.
// ----------------------------------------------------------------------------
interface nggcp_out_if;
  import nggcp_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_out;
  fid_t  field_id;
  logic  last_char;

  modport source (output valid, output char_out, output field_id, output last_char,
                  input ready);
  modport sink   (input valid, input char_out, input field_id, input last_char,
                  output ready);
endinterface

@@ design/nggcp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nggcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/nggcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// NMEA parser controller
// Header match, body and checksum sequencing, and result burst pacing.
// ----------------------------------------------------------------------------
`include "nmea_gga_gsa_checksum_parser_unit_defines.svh"

module nggcp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nggcp_pkg::nggcp_sts_t sts,
  output nggcp_pkg::nggcp_cmd_t cmd
);
  import nggcp_pkg::*;

  typedef enum logic [3:0] {
    S_HUNT, S_G1, S_P, S_G2, S_KIND, S_A, S_BODY, S_HEX1, S_HEX2,
    S_RD, S_LD, S_SEND
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    in_fire   = 1'b0;
    case (state_r)
      S_HUNT, S_G1, S_P, S_G2, S_KIND, S_A, S_BODY, S_HEX1, S_HEX2: begin
        in_ready = 1'b1;
        in_fire  = in_valid;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    case (state_r)
      S_HUNT: begin
        if (in_fire && sts.is_dollar) begin
          cmd.restart = 1'b1;
          state_nxt   = S_G1;
        end
      end
      S_G1, S_P, S_G2, S_KIND, S_A: begin
        if (in_fire) begin
          if ((state_r == S_G1 && sts.is_g) || (state_r == S_P && sts.is_p) ||
              (state_r == S_G2 && sts.is_g) ||
              (state_r == S_KIND && (sts.is_g || sts.is_s)) ||
              (state_r == S_A && sts.is_a)) begin
            cmd.take = 1'b1;
            case (state_r)
              S_G1:    state_nxt = S_P;
              S_P:     state_nxt = S_G2;
              S_G2:    state_nxt = S_KIND;
              S_KIND: begin
                cmd.set_kind = 1'b1;
                state_nxt    = S_A;
              end
              default: state_nxt = S_BODY;
            endcase
          end else if (sts.is_dollar) begin
            cmd.restart = 1'b1;
            state_nxt   = S_G1;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_BODY: begin
        if (in_fire) begin
          if (sts.is_star) begin
            state_nxt = S_HEX1;
          end else begin
            cmd.take = 1'b1;
          end
        end
      end
      S_HEX1: begin
        if (in_fire) begin
          cmd.hex_first = 1'b1;
          state_nxt     = S_HEX2;
        end
      end
      S_HEX2: begin
        if (in_fire) begin
          if (sts.sum_ok && !sts.none_to_send) begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_RD;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (sts.out_taken) begin
          state_nxt = sts.out_last ? S_HUNT : S_LD;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `NGGCP_ASSERT_NEXT(a_burst_end_hunts, clk, rst_n, sts.out_taken && sts.out_last, state_r == S_HUNT)

endmodule

@@ design/nggcp_dp.sv @@
// ----------------------------------------------------------------------------
// NMEA parser datapath
// Checksum, character store, digit capture and result output register.
// ----------------------------------------------------------------------------
`include "nmea_gga_gsa_checksum_parser_unit_defines.svh"

module nggcp_dp #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nggcp_pkg::char_t      in_char,
  input  nggcp_pkg::nggcp_cmd_t cmd,
  output nggcp_pkg::nggcp_sts_t sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output nggcp_pkg::char_t      out_char,
  output nggcp_pkg::fid_t       out_fid,
  output logic                  out_last
);
  import nggcp_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int ZW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  char_t            xor_r, xor_nxt;
  logic [3:0]       first_hex_r, first_hex_nxt;
  logic             hex_ok_r, hex_ok_nxt;
  logic             kind_r, kind_nxt;
  idx_t             idx_r, idx_nxt;
  logic [3:0]       commas_r, commas_nxt;
  logic             out_valid_r, out_valid_nxt;
  char_t            out_char_r, out_char_nxt;
  fid_t             out_fid_r, out_fid_nxt;
  logic             out_last_r, out_last_nxt;

  logic [4:0]       hex_in;
  logic             we;
  logic [AW-1:0]    raddr;
  char_t            rdata;
  logic             out_taken;
  logic             is_comma;
  logic [3:0]       commas_inc;
  idx_t             next_place;
  logic             gsa_last;

  nggcp_ram #(.WIDTH(CHAR_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_char),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign hex_in     = hex_decode(in_char);
  assign out_taken  = out_valid_r && out_ready;
  assign is_comma   = (rdata == CH_COMMA);
  assign commas_inc = commas_r + {3'b000, is_comma};
  assign next_place = idx_r + IDX_W'(1);
  assign gsa_last   = (ZW'(next_place) >= ZW'(GSA_LIMIT)) ||
                      (ZW'(next_place) >= ZW'(count_r)) ||
                      (commas_inc == GSA_COMMAS);
  assign raddr      = kind_r ? AW'(idx_r) : AW'(gga_pos(idx_r));
  assign we         = cmd.take && (count_r < CNT_W'(STORE_DEPTH));

  always_comb begin
    sts.is_dollar    = (in_char == CH_DOLLAR);
    sts.is_g         = (in_char == CH_G);
    sts.is_p         = (in_char == CH_P);
    sts.is_s         = (in_char == CH_S);
    sts.is_a         = (in_char == CH_A);
    sts.is_star      = (in_char == CH_STAR);
    sts.sum_ok       = hex_ok_r && hex_in[4] && ({first_hex_r, hex_in[3:0]} == xor_r);
    sts.none_to_send = kind_r && (ZW'(count_r) <= ZW'(GSA_FIRST));
    sts.out_taken    = out_taken;
    sts.out_last     = out_last_r;
  end

  always_comb begin
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    first_hex_nxt = first_hex_r;
    hex_ok_nxt    = hex_ok_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    commas_nxt    = commas_r;
    out_valid_nxt = out_taken ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_fid_nxt   = out_fid_r;
    out_last_nxt  = out_last_r;

    if (cmd.restart) begin
      count_nxt = '0;
      xor_nxt   = '0;
    end
    if (cmd.take) begin
      xor_nxt = xor_r ^ in_char;
      if (we) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (cmd.set_kind) begin
      kind_nxt = sts.is_s;
    end
    if (cmd.hex_first) begin
      first_hex_nxt = hex_in[3:0];
      hex_ok_nxt    = hex_in[4];
    end
    if (cmd.emit_init) begin
      idx_nxt    = kind_r ? GSA_FIRST : '0;
      commas_nxt = '0;
    end
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = rdata;
      out_fid_nxt   = kind_r ? FID_SAT : gga_fid(idx_r);
      out_last_nxt  = kind_r ? gsa_last : (idx_r == GGA_COUNT - IDX_W'(1));
      idx_nxt       = next_place;
      commas_nxt    = commas_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      xor_r       <= '0;
      first_hex_r <= '0;
      hex_ok_r    <= 1'b0;
      kind_r      <= 1'b0;
      idx_r       <= '0;
      commas_r    <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      first_hex_r <= first_hex_nxt;
      hex_ok_r    <= hex_ok_nxt;
      kind_r      <= kind_nxt;
      idx_r       <= idx_nxt;
      commas_r    <= commas_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_fid_r  <= out_fid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_fid   = out_fid_r;
  assign out_last  = out_last_r;

  `NGGCP_ASSERT_ALWAYS(a_count_bounded, clk, rst_n, count_r <= CNT_W'(STORE_DEPTH))
  `NGGCP_ASSERT_IMP(a_gga_ends_on_unit, clk, rst_n, out_valid_r && out_last_r && !kind_r, out_fid_r == FID_UNIT)

endmodule

@@ design/nmea_gga_gsa_checksum_parser_unit.sv @@
// ----------------------------------------------------------------------------
// NMEA GGA/GSA checksum parser
// Hunts for $GPGGA/$GPGSA sentences and emits selected fields once checked.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while parsing. The checksum covers every byte from
// the first G up to '*' and the first STORE_DEPTH of them land in a RAM with
// one write and one read port. When the two hex digits after '*' match, the
// block stops taking bytes and sends a burst: 39 characters for GGA, or up to
// 56 for GSA ending at the eighth comma or the end of the stored bytes. Each
// result is read from the RAM and then loaded into the output register, and
// the burst is stretched by any stall on the result side; input is accepted
// again once the last character has been transferred. GGA fields beyond the
// end of a short sentence come from whatever an earlier sentence left in the
// store.
// ----------------------------------------------------------------------------
`include "nmea_gga_gsa_checksum_parser_unit_defines.svh"

module nmea_gga_gsa_checksum_parser_unit #(
  parameter int STORE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  nggcp_in_if.sink    in_if,
  nggcp_out_if.source out_if
);
  import nggcp_pkg::*;

  nggcp_cmd_t cmd;
  nggcp_sts_t sts;
  logic       in_ready;
  logic       out_valid;
  char_t      out_char;
  fid_t       out_fid;
  logic       out_last;

  nggcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nggcp_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_if.char_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_fid   (out_fid),
    .out_last  (out_last)
  );

  assign in_if.ready      = in_ready;
  assign out_if.valid     = out_valid;
  assign out_if.char_out  = out_char;
  assign out_if.field_id  = out_fid;
  assign out_if.last_char = out_last;

  `NGGCP_ASSERT_IMP(a_no_input_during_burst, clk, rst_n, in_ready, !out_valid)

endmodule
